### hw/rtl/bcg_pkg.sv
// Shared types and constants for the circle rasterizer.
// No dependencies; used by every module of the block.

package bcg_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  localparam int COLOR_BITS = 24;

  typedef enum logic [1:0] {
    MV_HORZ,
    MV_DIAG,
    MV_VERT
  } move_t;

  typedef enum logic [1:0] {
    QD_PXPY,
    QD_NXPY,
    QD_NXNY,
    QD_PXNY
  } quad_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### hw/rtl/bcg_front.sv
// Front end: accepts start and step beats, runs one Bresenham decision per step beat
// on an active circle and pushes each new point into the point queue. Depends on bcg_pkg.

module bcg_front #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_opcode,
  input  logic signed [COORD_BITS-1:0]         in_center_x,
  input  logic signed [COORD_BITS-1:0]         in_center_y,
  input  logic [RADIUS_BITS-1:0]               in_radius,
  input  logic [bcg_pkg::COLOR_BITS-1:0]       in_color,
  input  bcg_pkg::qstat_t                      qstat,
  output logic                                 q_push,
  output logic [2*COORD_BITS+2*(RADIUS_BITS+1)+bcg_pkg::COLOR_BITS:0] q_wdata
);

  localparam int OFS_BITS = RADIUS_BITS + 1;
  localparam int ERR_BITS = RADIUS_BITS + 4;
  localparam int D_BITS   = ERR_BITS + 2;

  logic                           active_r, active_nxt;
  logic [OFS_BITS-1:0]            ofs_x_r, ofs_x_nxt;
  logic [OFS_BITS-1:0]            ofs_y_r, ofs_y_nxt;
  logic [ERR_BITS-1:0]            err_r, err_nxt;
  logic [COORD_BITS-1:0]          cx_r, cx_nxt;
  logic [COORD_BITS-1:0]          cy_r, cy_nxt;
  logic [bcg_pkg::COLOR_BITS-1:0] color_r, color_nxt;

  logic                accept;
  logic                done;
  logic [D_BITS-1:0]   x_w, y_w, e_w;
  logic [D_BITS-1:0]   t_lo, t_hi;
  logic [D_BITS-1:0]   x_s, y_s, e_s;
  logic                t_lo_le0, t_hi_le0;
  bcg_pkg::move_t      move;

  assign in_full = qstat.full;
  assign accept  = in_push && !qstat.full;

  assign x_w  = {{(D_BITS-OFS_BITS){1'b0}}, ofs_x_r};
  assign y_w  = {{(D_BITS-OFS_BITS){1'b0}}, ofs_y_r};
  assign e_w  = {{(D_BITS-ERR_BITS){err_r[ERR_BITS-1]}}, err_r};
  assign t_lo = (e_w << 1) + (y_w << 1) - D_BITS'(1);
  assign t_hi = (e_w << 1) - (x_w << 1) - D_BITS'(1);
  assign t_lo_le0 = t_lo[D_BITS-1] || (t_lo == '0);
  assign t_hi_le0 = t_hi[D_BITS-1] || (t_hi == '0);

  always_comb begin
    if (err_r[ERR_BITS-1]) begin
      move = t_lo_le0 ? bcg_pkg::MV_HORZ : bcg_pkg::MV_DIAG;
    end else if (err_r != '0) begin
      move = t_hi_le0 ? bcg_pkg::MV_DIAG : bcg_pkg::MV_VERT;
    end else begin
      move = bcg_pkg::MV_DIAG;
    end
  end

  always_comb begin
    case (move)
      bcg_pkg::MV_HORZ: begin
        x_s = x_w + D_BITS'(1);
        y_s = y_w;
        e_s = e_w + (x_w << 1) + D_BITS'(3);
      end
      bcg_pkg::MV_DIAG: begin
        x_s = x_w + D_BITS'(1);
        y_s = y_w - D_BITS'(1);
        e_s = e_w + ((x_w - y_w) << 1) + D_BITS'(6);
      end
      bcg_pkg::MV_VERT: begin
        x_s = x_w;
        y_s = y_w - D_BITS'(1);
        e_s = e_w - (y_w << 1) + D_BITS'(3);
      end
      default: begin
        x_s = x_w;
        y_s = y_w;
        e_s = e_w;
      end
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    ofs_x_nxt  = ofs_x_r;
    ofs_y_nxt  = ofs_y_r;
    err_nxt    = err_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    q_push     = 1'b0;
    if (accept) begin
      if (in_opcode == bcg_pkg::OP_START) begin
        cx_nxt    = in_center_x;
        cy_nxt    = in_center_y;
        color_nxt = in_color;
        ofs_x_nxt = '0;
        ofs_y_nxt = {1'b0, in_radius};
        err_nxt   = ERR_BITS'(2) - {3'b000, in_radius, 1'b0};
        q_push    = 1'b1;
      end else if (active_r) begin
        ofs_x_nxt = x_s[OFS_BITS-1:0];
        ofs_y_nxt = y_s[OFS_BITS-1:0];
        err_nxt   = e_s[ERR_BITS-1:0];
        q_push    = 1'b1;
      end
    end
    done = (ofs_y_nxt == '0);
    if (q_push) begin
      active_nxt = !done;
    end
    q_wdata = {cx_nxt, cy_nxt, ofs_x_nxt, ofs_y_nxt, color_nxt, done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ofs_x_r <= ofs_x_nxt;
    ofs_y_r <= ofs_y_nxt;
    err_r   <= err_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    color_r <= color_nxt;
  end

endmodule

### hw/rtl/bcg_queue.sv
// Two-entry point queue between the front end and the pixel back end.
// Depends on bcg_pkg for depth constants and the status struct.

module bcg_queue #(
  parameter int WIDTH = 71
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output bcg_pkg::qstat_t  qstat
);

  logic [WIDTH-1:0]          slot_r [bcg_pkg::Q_DEPTH];
  logic [bcg_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bcg_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bcg_pkg::Q_CW-1:0]  count_r, count_nxt;
  logic                      do_push, do_pop;

  assign qstat.full  = (count_r == bcg_pkg::Q_CW'(bcg_pkg::Q_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rdata       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hw/rtl/bcg_back.sv
// Back end: mirrors each queued point into four pixels, one per beat,
// through a registered output stage. Depends on bcg_pkg.

module bcg_back #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bcg_pkg::qstat_t                      qstat,
  input  logic [2*COORD_BITS+2*(RADIUS_BITS+1)+bcg_pkg::COLOR_BITS:0] q_rdata,
  output logic                                 q_pop,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [COORD_BITS:0]           out_pixel_x,
  output logic signed [COORD_BITS:0]           out_pixel_y,
  output logic [bcg_pkg::COLOR_BITS-1:0]       out_pixel_color,
  output logic                                 out_last_of_point,
  output logic                                 out_circle_done
);

  localparam int OFS_BITS = RADIUS_BITS + 1;
  localparam int PIX_BITS = COORD_BITS + 1;
  localparam int S_BITS   = COORD_BITS + RADIUS_BITS + 2;
  localparam int COL_LO   = 1;
  localparam int Y_LO     = COL_LO + bcg_pkg::COLOR_BITS;
  localparam int X_LO     = Y_LO + OFS_BITS;
  localparam int CY_LO    = X_LO + OFS_BITS;
  localparam int CX_LO    = CY_LO + COORD_BITS;

  logic                           valid_r, valid_nxt;
  bcg_pkg::quad_t                 quad_r, quad_nxt;
  logic [PIX_BITS-1:0]            px_r, px_nxt;
  logic [PIX_BITS-1:0]            py_r, py_nxt;
  logic [bcg_pkg::COLOR_BITS-1:0] color_r;
  logic                           last_r, last_nxt;
  logic                           done_r;

  logic                   load;
  logic [COORD_BITS-1:0]  cx, cy;
  logic [OFS_BITS-1:0]    ox, oy;
  logic [S_BITS-1:0]      cx_s, cy_s, ox_s, oy_s;
  logic [S_BITS-1:0]      x_pos, x_neg, y_pos, y_neg;

  assign cx = q_rdata[CX_LO +: COORD_BITS];
  assign cy = q_rdata[CY_LO +: COORD_BITS];
  assign ox = q_rdata[X_LO +: OFS_BITS];
  assign oy = q_rdata[Y_LO +: OFS_BITS];

  assign cx_s  = {{(RADIUS_BITS+2){cx[COORD_BITS-1]}}, cx};
  assign cy_s  = {{(RADIUS_BITS+2){cy[COORD_BITS-1]}}, cy};
  assign ox_s  = {{(COORD_BITS+1){1'b0}}, ox};
  assign oy_s  = {{(COORD_BITS+1){1'b0}}, oy};
  assign x_pos = cx_s + ox_s;
  assign x_neg = cx_s - ox_s;
  assign y_pos = cy_s + oy_s;
  assign y_neg = cy_s - oy_s;

  assign load  = !qstat.empty && (!valid_r || out_pop);
  assign q_pop = load && (quad_r == bcg_pkg::QD_PXNY);

  always_comb begin
    case (quad_r)
      bcg_pkg::QD_PXPY: begin
        px_nxt   = x_pos[PIX_BITS-1:0];
        py_nxt   = y_pos[PIX_BITS-1:0];
        last_nxt = 1'b0;
        quad_nxt = bcg_pkg::QD_NXPY;
      end
      bcg_pkg::QD_NXPY: begin
        px_nxt   = x_neg[PIX_BITS-1:0];
        py_nxt   = y_pos[PIX_BITS-1:0];
        last_nxt = 1'b0;
        quad_nxt = bcg_pkg::QD_NXNY;
      end
      bcg_pkg::QD_NXNY: begin
        px_nxt   = x_neg[PIX_BITS-1:0];
        py_nxt   = y_neg[PIX_BITS-1:0];
        last_nxt = 1'b0;
        quad_nxt = bcg_pkg::QD_PXNY;
      end
      bcg_pkg::QD_PXNY: begin
        px_nxt   = x_pos[PIX_BITS-1:0];
        py_nxt   = y_neg[PIX_BITS-1:0];
        last_nxt = 1'b1;
        quad_nxt = bcg_pkg::QD_PXPY;
      end
      default: begin
        px_nxt   = x_pos[PIX_BITS-1:0];
        py_nxt   = y_pos[PIX_BITS-1:0];
        last_nxt = 1'b0;
        quad_nxt = bcg_pkg::QD_PXPY;
      end
    endcase
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      quad_r  <= bcg_pkg::QD_PXPY;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        quad_r <= quad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      color_r <= q_rdata[COL_LO +: bcg_pkg::COLOR_BITS];
      last_r  <= last_nxt;
      done_r  <= q_rdata[0];
    end
  end

  assign out_empty         = !valid_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_pixel_color   = color_r;
  assign out_last_of_point = last_r;
  assign out_circle_done   = done_r;

endmodule

### hw/rtl/bresenham_circle_generator_core.sv
// Bresenham circle rasterizer: front end, two-entry point queue, pixel back end.
// Path: a beat's point is written into the point queue, and its pixels then pass through
// the back-end output register. Throughput: set by the single output register of the back
// end, issuing one mirrored pixel per cycle while out_pop takes it; beats stall on in_full.
// Reset: synchronous, active low; clears to idle with queue and outputs empty.
// Depends on bcg_pkg, bcg_front, bcg_queue and bcg_back.

module bresenham_circle_generator_core #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_opcode,
  input  logic signed [COORD_BITS-1:0]         in_center_x,
  input  logic signed [COORD_BITS-1:0]         in_center_y,
  input  logic [RADIUS_BITS-1:0]               in_radius,
  input  logic [bcg_pkg::COLOR_BITS-1:0]       in_color,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [COORD_BITS:0]           out_pixel_x,
  output logic signed [COORD_BITS:0]           out_pixel_y,
  output logic [bcg_pkg::COLOR_BITS-1:0]       out_pixel_color,
  output logic                                 out_last_of_point,
  output logic                                 out_circle_done
);

  localparam int REC_BITS = 2*COORD_BITS + 2*(RADIUS_BITS+1) + bcg_pkg::COLOR_BITS + 1;

  bcg_pkg::qstat_t       qstat;
  logic                  q_push, q_pop;
  logic [REC_BITS-1:0]   q_wdata, q_rdata;

  bcg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_opcode   (in_opcode),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_color    (in_color),
    .qstat       (qstat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  bcg_queue #(
    .WIDTH (REC_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  bcg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .qstat             (qstat),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_point (out_last_of_point),
    .out_circle_done   (out_circle_done)
  );

endmodule
